[hdl/shce3_pkg.sv]
// shared types, constants and the basis constant table for the sh color evaluator
// no dependencies; used by shce3_front, shce3_back and sh_color_eval_deg3_core
package shce3_pkg;

	localparam int MAX_DEGREE = 3;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [1:0] DEG_RESET = 2'd3;

	// one coefficient item as it sits in the queue between front and back
	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [3:0]         basis_index;
		logic signed [15:0] coeff_red;
		logic signed [15:0] coeff_green;
		logic signed [15:0] coeff_blue;
		logic               last_coeff;
		logic               active;
	} item_t;

	// normalization constants, 14 fraction bits
	function automatic logic signed [16:0] basis_const(input logic [3:0] idx);
		logic signed [16:0] c;
		unique case (idx)
			4'd0:  c = 17'sd4622;
			4'd1:  c = -17'sd8005;
			4'd2:  c = 17'sd8005;
			4'd3:  c = -17'sd8005;
			4'd4:  c = 17'sd17900;
			4'd5:  c = -17'sd17900;
			4'd6:  c = 17'sd5167;
			4'd7:  c = -17'sd17900;
			4'd8:  c = 17'sd8950;
			4'd9:  c = -17'sd9667;
			4'd10: c = 17'sd47360;
			4'd11: c = -17'sd7488;
			4'd12: c = 17'sd6114;
			4'd13: c = -17'sd7488;
			4'd14: c = 17'sd23680;
			4'd15: c = -17'sd9667;
		endcase
		return c;
	endfunction

endpackage

[hdl/shce3_front.sv]
// front end: input handshake, degree register, index classification and item queue
// depends on shce3_pkg
module shce3_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [95:0]           s_tdata,
	input  logic [3:0]            s_tuser,
	input  logic                  s_tlast,
	output logic                  q_valid,
	output shce3_pkg::item_t      q_item,
	input  logic                  q_ready
);

	localparam logic [shce3_pkg::QPTR_W:0] QFULL = (shce3_pkg::QPTR_W + 1)'(shce3_pkg::QDEPTH);
	localparam logic [1:0] DEG_MAX = 2'(shce3_pkg::MAX_DEGREE);

	logic [1:0]                   deg_q;
	logic [1:0]                   eff_deg;
	logic [4:0]                   count;
	shce3_pkg::item_t             in_item;
	shce3_pkg::item_t             mem_q [shce3_pkg::QDEPTH];
	logic [shce3_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [shce3_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [shce3_pkg::QPTR_W:0]   cnt_q;
	logic                         push;
	logic                         pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= shce3_pkg::DEG_RESET;
		end else if (cfg_we) begin
			deg_q <= cfg_wdata;
		end
	end

	always_comb begin
		eff_deg = (deg_q > DEG_MAX) ? DEG_MAX : deg_q;
		unique case (eff_deg)
			2'd0: count = 5'd1;
			2'd1: count = 5'd4;
			2'd2: count = 5'd9;
			2'd3: count = 5'd16;
		endcase
	end

	always_comb begin
		in_item.dir_x       = s_tdata[15:0];
		in_item.dir_y       = s_tdata[31:16];
		in_item.dir_z       = s_tdata[47:32];
		in_item.coeff_red   = s_tdata[63:48];
		in_item.coeff_green = s_tdata[79:64];
		in_item.coeff_blue  = s_tdata[95:80];
		in_item.basis_index = s_tuser;
		in_item.last_coeff  = s_tlast;
		in_item.active      = {1'b0, s_tuser} < count;
	end

	assign s_tready = cnt_q != QFULL;
	assign q_valid  = cnt_q != '0;
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (shce3_pkg::QPTR_W + 1)'(push) - (shce3_pkg::QPTR_W + 1)'(pop);
		end
	end

	// fill level tracks pushes and pops exactly
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (cnt_q == $past(cnt_q) + (shce3_pkg::QPTR_W + 1)'($past(push))
			- (shce3_pkg::QPTR_W + 1)'($past(pop))))
		else $error("queue fill level out of step");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QFULL)
		else $error("queue fill level beyond depth");

endmodule

[hdl/shce3_back.sv]
// back end: basis evaluation pipeline, per-channel accumulators and output register
// depends on shce3_pkg
module shce3_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  shce3_pkg::item_t      q_item,
	output logic                  q_ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata
);

	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_15   = 2'd1;
	localparam logic [1:0] SH_30   = 2'd2;

	logic adv;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	shce3_pkg::item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8;

	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [33:0] opa_s2;
	logic signed [15:0] opb_s2;
	logic [1:0]         cls_s2, cls_s3;
	logic signed [49:0] prod_s3;
	logic signed [19:0] poly_s4;
	logic signed [36:0] prod2_s5;
	logic signed [23:0] yb_s6;
	logic signed [39:0] pr_s7 [3];
	logic signed [24:0] term_s8 [3];

	logic signed [39:0] acc_q [3];
	logic signed [39:0] sum_new [3];
	logic signed [15:0] color [3];
	logic               m_tvalid_q;
	logic [47:0]        m_tdata_q;

	// combinational helpers
	logic signed [33:0] xx34, yy34, zz34, xy34, xz34, yz34;
	logic signed [33:0] dx34, dy34, dz34;
	logic signed [33:0] p_2z_xy, p_4z_xy, p_3x_y, p_2z_3xy, p_x_y, p_x_3y;
	logic signed [33:0] opa_d;
	logic signed [15:0] opb_d;
	logic [1:0]         cls_d;
	logic signed [49:0] r15, r30;
	logic signed [19:0] poly_d;

	assign adv      = !m_tvalid_q || m_tready;
	assign q_ready  = adv;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// second stage operand selection
	always_comb begin
		xx34 = 34'(xx_s1);
		yy34 = 34'(yy_s1);
		zz34 = 34'(zz_s1);
		xy34 = 34'(xy_s1);
		xz34 = 34'(xz_s1);
		yz34 = 34'(yz_s1);
		dx34 = 34'($signed(it_s1.dir_x));
		dy34 = 34'($signed(it_s1.dir_y));
		dz34 = 34'($signed(it_s1.dir_z));
		p_2z_xy  = (zz34 <<< 1) - xx34 - yy34;
		p_4z_xy  = (zz34 <<< 2) - xx34 - yy34;
		p_3x_y   = (xx34 <<< 1) + xx34 - yy34;
		p_2z_3xy = (zz34 <<< 1) - (xx34 <<< 1) - xx34 - (yy34 <<< 1) - yy34;
		p_x_y    = xx34 - yy34;
		p_x_3y   = xx34 - (yy34 <<< 1) - yy34;
		unique case (it_s1.basis_index)
			4'd0:  begin opa_d = 34'sd32768; opb_d = 16'sd1;          cls_d = SH_NONE; end
			4'd1:  begin opa_d = dy34;       opb_d = 16'sd1;          cls_d = SH_NONE; end
			4'd2:  begin opa_d = dz34;       opb_d = 16'sd1;          cls_d = SH_NONE; end
			4'd3:  begin opa_d = dx34;       opb_d = 16'sd1;          cls_d = SH_NONE; end
			4'd4:  begin opa_d = xy34;       opb_d = 16'sd1;          cls_d = SH_15;   end
			4'd5:  begin opa_d = yz34;       opb_d = 16'sd1;          cls_d = SH_15;   end
			4'd6:  begin opa_d = p_2z_xy;    opb_d = 16'sd1;          cls_d = SH_15;   end
			4'd7:  begin opa_d = xz34;       opb_d = 16'sd1;          cls_d = SH_15;   end
			4'd8:  begin opa_d = p_x_y;      opb_d = 16'sd1;          cls_d = SH_15;   end
			4'd9:  begin opa_d = p_3x_y;     opb_d = it_s1.dir_y;     cls_d = SH_30;   end
			4'd10: begin opa_d = xy34;       opb_d = it_s1.dir_z;     cls_d = SH_30;   end
			4'd11: begin opa_d = p_4z_xy;    opb_d = it_s1.dir_y;     cls_d = SH_30;   end
			4'd12: begin opa_d = p_2z_3xy;   opb_d = it_s1.dir_z;     cls_d = SH_30;   end
			4'd13: begin opa_d = p_4z_xy;    opb_d = it_s1.dir_x;     cls_d = SH_30;   end
			4'd14: begin opa_d = p_x_y;      opb_d = it_s1.dir_z;     cls_d = SH_30;   end
			4'd15: begin opa_d = p_x_3y;     opb_d = it_s1.dir_x;     cls_d = SH_30;   end
		endcase
	end

	// fourth stage rounding of the polynomial to q.15
	always_comb begin
		r15 = (prod_s3 + 50'sd16384) >>> 15;
		r30 = (prod_s3 + 50'sd536870912) >>> 30;
		unique case (cls_s3)
			SH_NONE: poly_d = 20'(prod_s3);
			SH_15:   poly_d = 20'(r15);
			default: poly_d = 20'(r30);
		endcase
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= q_item;
			xx_s1 <= 32'($signed(q_item.dir_x) * $signed(q_item.dir_x));
			yy_s1 <= 32'($signed(q_item.dir_y) * $signed(q_item.dir_y));
			zz_s1 <= 32'($signed(q_item.dir_z) * $signed(q_item.dir_z));
			xy_s1 <= 32'($signed(q_item.dir_x) * $signed(q_item.dir_y));
			xz_s1 <= 32'($signed(q_item.dir_x) * $signed(q_item.dir_z));
			yz_s1 <= 32'($signed(q_item.dir_y) * $signed(q_item.dir_z));

			it_s2  <= it_s1;
			opa_s2 <= opa_d;
			opb_s2 <= opb_d;
			cls_s2 <= cls_d;

			it_s3   <= it_s2;
			cls_s3  <= cls_s2;
			prod_s3 <= 50'(opa_s2) * 50'(opb_s2);

			it_s4   <= it_s3;
			poly_s4 <= poly_d;

			it_s5    <= it_s4;
			prod2_s5 <= 37'(poly_s4) * 37'(shce3_pkg::basis_const(it_s4.basis_index));

			it_s6 <= it_s5;
			yb_s6 <= 24'((prod2_s5 + 37'sd8192) >>> 14);

			it_s7    <= it_s6;
			pr_s7[0] <= 40'(yb_s6) * 40'($signed(it_s6.coeff_red));
			pr_s7[1] <= 40'(yb_s6) * 40'($signed(it_s6.coeff_green));
			pr_s7[2] <= 40'(yb_s6) * 40'($signed(it_s6.coeff_blue));

			it_s8 <= it_s7;
			for (int c = 0; c < 3; c++) begin
				term_s8[c] <= 25'((pr_s7[c] + 40'sd16384) >>> 15);
			end
		end
	end

	// accumulate with 40-bit saturation, then bias and clamp to q3.12
	always_comb begin
		logic signed [40:0] s41;
		logic signed [40:0] b41;
		for (int c = 0; c < 3; c++) begin
			s41 = 41'(acc_q[c]) + (it_s8.active ? 41'(term_s8[c]) : 41'sd0);
			if (s41[40] != s41[39]) begin
				sum_new[c] = s41[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
			end else begin
				sum_new[c] = s41[39:0];
			end
			b41 = 41'(sum_new[c]) + 41'sd2048;
			if (b41 > 41'sd32767) begin
				color[c] = 16'sh7fff;
			end else if (b41 < -41'sd32768) begin
				color[c] = 16'sh8000;
			end else begin
				color[c] = b41[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q[0]   <= '0;
			acc_q[1]   <= '0;
			acc_q[2]   <= '0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= v_s8 && it_s8.last_coeff;
			if (v_s8) begin
				for (int c = 0; c < 3; c++) begin
					acc_q[c] <= it_s8.last_coeff ? 40'sd0 : sum_new[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s8 && it_s8.last_coeff) begin
			m_tdata_q <= {color[2], color[1], color[0]};
		end
	end

	// a splat that finishes leaves all three sums cleared
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s8 && it_s8.last_coeff) |=>
			(acc_q[0] == 40'sd0 && acc_q[1] == 40'sd0 && acc_q[2] == 40'sd0))
		else $error("sums not cleared after last item");

	// a result only appears behind a last item leaving the pipeline
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(v_s8 && it_s8.last_coeff))
		else $error("result without a last item");

	// the pipeline freezes while the output is blocked
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (v_s8 == $past(v_s8) && v_s1 == $past(v_s1)))
		else $error("pipeline moved while output blocked");

endmodule

[hdl/sh_color_eval_deg3_core.sv]
// top level of the real spherical harmonics color evaluator, degrees 0 to 3
// depends on shce3_pkg, shce3_front and shce3_back
//
// Streams one coefficient triple (red, green, blue, Q3.12) per item together with its
// basis index 0..15 and the view direction (Q1.15); each coefficient is scaled by the
// harmonic basis value at that direction and summed per channel. The item that carries
// tlast closes the splat: the three sums plus 0.5 come out saturated to Q3.12 as one
// result item and the sums restart from zero. Indices at or beyond (degree+1)^2 add
// nothing, though their tlast still produces a result. The degree register (reset 3) is
// written through cfg_we/cfg_wdata and should only change between splats with the block
// drained. Throughput is one item per clock while the output is not blocked; the front end
// buffers up to four items in a queue so input and output stall independently. From
// acceptance a result passes through the queue, eight stages of products and rounding, and
// the output register. The rate is bounded by the combinational accumulate-and-saturate
// step in the last stage, which feeds back into its own accumulator register.
module sh_color_eval_deg3_core (
	input  logic        clk,
	input  logic        arst_n,

	// degree register write
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,

	// coefficient items
	input  logic        s_tvalid,
	output logic        s_tready,
	// dir_x [15:0], dir_y [31:16], dir_z [47:32], coeff_red [63:48],
	// coeff_green [79:64], coeff_blue [95:80]
	input  logic [95:0] s_tdata,
	// basis_index [3:0]
	input  logic [3:0]  s_tuser,
	// last_coeff
	input  logic        s_tlast,

	// color result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// color_red [15:0], color_green [31:16], color_blue [47:32]
	output logic [47:0] m_tdata
);

	// queue handoff between classification and evaluation
	logic             q_valid;
	logic             q_ready;
	shce3_pkg::item_t q_item;

	// front: degree register, index range check, item queue
	shce3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_ready  (q_ready)
	);

	// back: basis polynomial, constant scaling, channel products, accumulators
	shce3_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_ready (q_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
